// ===== rtl/core/fapc_pkg.sv =====
// Shared types, constants and saturation helper for the four-axis position controller.
`default_nettype none
package fapc_pkg;

	localparam int DATA_WIDTH = 32;

	localparam int IO_W      = 32;
	localparam int NUM_IN    = 7;
	localparam int NUM_OUT   = 4;
	localparam int GAIN_W    = 16;
	localparam int ERR_W     = DATA_WIDTH + 1;
	localparam int MOP_W     = GAIN_W + 1;
	localparam int PROD_W    = ERR_W + MOP_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int SAT_W     = ACC_W;
	localparam int DT_SHIFT  = 16;
	localparam int PID_SHIFT = 12;

	localparam logic [1:0] CMD_ODOM       = 2'd0;
	localparam logic [1:0] CMD_TARGET_POS = 2'd1;
	localparam logic [1:0] CMD_TARGET_VEL = 2'd2;
	localparam logic [1:0] CMD_TICK       = 2'd3;

	localparam logic [2:0] REG_GAIN_P_XY   = 3'd0;
	localparam logic [2:0] REG_GAIN_I_XY   = 3'd1;
	localparam logic [2:0] REG_GAIN_D_XY   = 3'd2;
	localparam logic [2:0] REG_GAIN_P_Z    = 3'd3;
	localparam logic [2:0] REG_GAIN_I_Z    = 3'd4;
	localparam logic [2:0] REG_GAIN_D_Z    = 3'd5;
	localparam logic [2:0] REG_TICK_PERIOD = 3'd6;
	localparam logic [2:0] REG_ENABLE      = 3'd7;

	localparam logic [GAIN_W-1:0] RST_GAIN_P = 16'd8192;
	localparam logic [GAIN_W-1:0] RST_GAIN_I = 16'd410;
	localparam logic [GAIN_W-1:0] RST_GAIN_D = 16'd2458;
	localparam logic [GAIN_W-1:0] RST_DT     = 16'd655;

	localparam logic signed [SAT_W-1:0] DW_MAX =
		SAT_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SAT_W-1:0] DW_MIN = -DW_MAX - 1;
	localparam logic signed [SAT_W-1:0] Q_PI     = SAT_W'(205887);
	localparam logic signed [SAT_W-1:0] Q_TWO_PI = SAT_W'(411775);

	// Clamps a wide signed value to the signed internal data range.
	function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [SAT_W-1:0] v);
		if (v > DW_MAX) begin
			return DW_MAX[DATA_WIDTH-1:0];
		end else if (v < DW_MIN) begin
			return DW_MIN[DATA_WIDTH-1:0];
		end
		return v[DATA_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/four_axis_pid_position_controller.sv =====
// Four-axis PID position controller: register file, sequencer and shared multiplier.
`default_nettype none
// Position controller for x, y, z and yaw in Q16.16. Odometry, target pose and target
// velocity transactions are taken while the block is idle. A tick transaction, when the block is
// enabled and odometry has been seen, runs a sequence through one shared multiplier with a
// registered product: yaw unwrap and error forming come first, then each of x, y
// and z takes five multiplier steps (error times dt, the P, I and D terms, then the sum),
// and a last step hands the result to the output register once the output side is free.
// The input side is not ready while a tick is being worked on; other transactions are
// taken while an earlier result still waits on the output.
// Configuration writes are always taken and should only be made while the block is idle.
module four_axis_pid_position_controller (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Input stream.
	input  wire logic                                  s_tvalid,
	output      logic                                  s_tready,
	// tdata, low bit up: pos_x, pos_y, pos_z, heading, vel_x, vel_y, vel_z (32 bits each).
	input  wire logic [fapc_pkg::NUM_IN*fapc_pkg::IO_W-1:0]  s_tdata,
	// tuser: command.
	input  wire logic [1:0]                            s_tuser,
	// Result stream.
	output      logic                                  m_tvalid,
	input  wire logic                                  m_tready,
	// tdata, low bit up: cmd_vel_x, cmd_vel_y, cmd_vel_z, cmd_yaw_rate (32 bits each).
	output      logic [fapc_pkg::NUM_OUT*fapc_pkg::IO_W-1:0] m_tdata,
	// Configuration write channel.
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic [2:0]                            cfg_index,
	input  wire logic [fapc_pkg::GAIN_W-1:0]           cfg_data
);
	import fapc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_WRAP,
		ST_ERR,
		ST_MUL,
		ST_DONE
	} state_t;

	// Multiplier steps for one axis.
	typedef enum logic [2:0] {
		OP_DT,
		OP_P,
		OP_I,
		OP_D,
		OP_SUM
	} op_t;

	state_t state_q;

	logic [GAIN_W-1:0] gain_p_xy_q, gain_i_xy_q, gain_d_xy_q;
	logic [GAIN_W-1:0] gain_p_z_q, gain_i_z_q, gain_d_z_q;
	logic [GAIN_W-1:0] dt_q;
	logic              enable_q;

	logic signed [DATA_WIDTH-1:0] meas_pos_q [4];
	logic signed [DATA_WIDTH-1:0] meas_vel_q [3];
	logic signed [DATA_WIDTH-1:0] tgt_pos_q  [4];
	logic signed [DATA_WIDTH-1:0] tgt_vel_q  [3];
	logic signed [DATA_WIDTH-1:0] integ_q    [3];
	logic                         odom_seen_q;

	logic signed [ERR_W-1:0]      diff_q;
	logic signed [ERR_W-1:0]      err_q  [4];
	logic signed [ERR_W-1:0]      errd_q [3];
	logic signed [PROD_W-1:0]     prod_q;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [DATA_WIDTH-1:0] res_q  [3];
	logic [1:0]                   axis_q;
	op_t                          op_q;

	logic [NUM_OUT*IO_W-1:0] out_q;
	logic                    m_valid_q;

	logic                     in_fire;
	logic                     out_free;
	logic                     use_xy;
	logic [GAIN_W-1:0]        gain_sel;
	logic signed [ERR_W-1:0]  mul_a;
	logic signed [MOP_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] mul_res;
	logic signed [SAT_W-1:0]  integ_sum;
	logic signed [ACC_W-1:0]  pid_sum;
	logic signed [DATA_WIDTH-1:0] yaw_rate;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid & s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = out_q;

	assign use_xy = (axis_q != 2'd2);

	// Operand selection for the shared multiplier, one product per sequencer step.
	always_comb begin
		gain_sel = dt_q;
		mul_a    = err_q[axis_q];
		case (op_q)
			OP_DT: begin
				gain_sel = dt_q;
				mul_a    = err_q[axis_q];
			end
			OP_P: begin
				gain_sel = use_xy ? gain_p_xy_q : gain_p_z_q;
				mul_a    = err_q[axis_q];
			end
			OP_I: begin
				gain_sel = use_xy ? gain_i_xy_q : gain_i_z_q;
				mul_a    = ERR_W'(integ_q[axis_q]);
			end
			OP_D: begin
				gain_sel = use_xy ? gain_d_xy_q : gain_d_z_q;
				mul_a    = errd_q[axis_q];
			end
			default: begin
				gain_sel = dt_q;
				mul_a    = err_q[axis_q];
			end
		endcase
		mul_b   = signed'({1'b0, gain_sel});
		mul_res = mul_a * mul_b;
	end

	assign integ_sum = SAT_W'(integ_q[axis_q]) + SAT_W'(prod_q >>> DT_SHIFT);
	assign pid_sum   = acc_q + ACC_W'(prod_q);
	assign yaw_rate  = sat_dw(SAT_W'(err_q[3]) >>> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gain_p_xy_q <= RST_GAIN_P;
			gain_i_xy_q <= RST_GAIN_I;
			gain_d_xy_q <= RST_GAIN_D;
			gain_p_z_q  <= RST_GAIN_P;
			gain_i_z_q  <= RST_GAIN_I;
			gain_d_z_q  <= RST_GAIN_D;
			dt_q        <= RST_DT;
			enable_q    <= 1'b0;
			odom_seen_q <= 1'b0;
			m_valid_q   <= 1'b0;
			axis_q      <= '0;
			op_q        <= OP_DT;
			for (int i = 0; i < 4; i++) begin
				meas_pos_q[i] <= '0;
				tgt_pos_q[i]  <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				meas_vel_q[i] <= '0;
				tgt_vel_q[i]  <= '0;
				integ_q[i]    <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GAIN_P_XY:   gain_p_xy_q <= cfg_data;
					REG_GAIN_I_XY:   gain_i_xy_q <= cfg_data;
					REG_GAIN_D_XY:   gain_d_xy_q <= cfg_data;
					REG_GAIN_P_Z:    gain_p_z_q  <= cfg_data;
					REG_GAIN_I_Z:    gain_i_z_q  <= cfg_data;
					REG_GAIN_D_Z:    gain_d_z_q  <= cfg_data;
					REG_TICK_PERIOD: dt_q        <= cfg_data;
					REG_ENABLE:      enable_q    <= cfg_data[0];
					default: ;
				endcase
			end

			// In the final step the output register is reloaded, which covers this case.
			if (m_valid_q && m_tready && state_q != ST_DONE) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (s_tuser)
							CMD_ODOM: begin
								for (int i = 0; i < 4; i++) begin
									meas_pos_q[i] <= sat_dw(SAT_W'($signed(s_tdata[IO_W*i +: IO_W])));
								end
								for (int i = 0; i < 3; i++) begin
									meas_vel_q[i] <=
										sat_dw(SAT_W'($signed(s_tdata[IO_W*(i+4) +: IO_W])));
								end
								odom_seen_q <= 1'b1;
							end
							CMD_TARGET_POS: begin
								for (int i = 0; i < 4; i++) begin
									tgt_pos_q[i] <= sat_dw(SAT_W'($signed(s_tdata[IO_W*i +: IO_W])));
								end
							end
							CMD_TARGET_VEL: begin
								for (int i = 0; i < 3; i++) begin
									tgt_vel_q[i] <=
										sat_dw(SAT_W'($signed(s_tdata[IO_W*(i+4) +: IO_W])));
								end
							end
							CMD_TICK: begin
								if (enable_q && odom_seen_q) begin
									state_q <= ST_DIFF;
								end
							end
							default: ;
						endcase
					end
				end
				ST_DIFF: begin
					diff_q  <= ERR_W'(tgt_pos_q[3]) - ERR_W'(meas_pos_q[3]);
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					// Unwrap the measured yaw when it lies strictly more than pi from the target.
					if (SAT_W'(diff_q) > Q_PI || SAT_W'(diff_q) < -Q_PI) begin
						if (diff_q < 0) begin
							meas_pos_q[3] <= sat_dw(SAT_W'(meas_pos_q[3]) - Q_TWO_PI);
						end else begin
							meas_pos_q[3] <= sat_dw(SAT_W'(meas_pos_q[3]) + Q_TWO_PI);
						end
					end
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					for (int i = 0; i < 4; i++) begin
						err_q[i] <= ERR_W'(tgt_pos_q[i]) - ERR_W'(meas_pos_q[i]);
					end
					for (int i = 0; i < 3; i++) begin
						errd_q[i] <= ERR_W'(tgt_vel_q[i]) - ERR_W'(meas_vel_q[i]);
					end
					axis_q  <= '0;
					op_q    <= OP_DT;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= mul_res;
					case (op_q)
						OP_DT: op_q <= OP_P;
						OP_P: begin
							integ_q[axis_q] <= sat_dw(integ_sum);
							op_q            <= OP_I;
						end
						OP_I: begin
							acc_q <= ACC_W'(prod_q);
							op_q  <= OP_D;
						end
						OP_D: begin
							acc_q <= pid_sum;
							op_q  <= OP_SUM;
						end
						default: begin
							res_q[axis_q] <= sat_dw(SAT_W'(pid_sum >>> PID_SHIFT));
							op_q          <= OP_DT;
							if (axis_q == 2'd2) begin
								state_q <= ST_DONE;
							end else begin
								axis_q <= axis_q + 2'd1;
							end
						end
					endcase
				end
				ST_DONE: begin
					if (out_free) begin
						out_q     <= {IO_W'(yaw_rate), IO_W'(res_q[2]), IO_W'(res_q[1]),
							IO_W'(res_q[0])};
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// An active tick starts the sequence; anything else leaves the block idle.
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_tuser == CMD_TICK && enable_q && odom_seen_q |=> state_q == ST_DIFF)
		else $error("active tick did not start the sequence");

	a_other_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !(s_tuser == CMD_TICK && enable_q && odom_seen_q) |=> state_q == ST_IDLE)
		else $error("non-tick transaction left the idle state");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the final step");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> axis_q != 2'd3 && op_q <= OP_SUM)
		else $error("sequencer counters out of range");

	a_odom_flag: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_tuser == CMD_ODOM |=> odom_seen_q)
		else $error("odometry flag not set");

endmodule
`default_nettype wire
